FILE: rtl/rste_pkg.sv
// ----------------------------------------------------------------------------
// rste_pkg
// Types and constants shared by the rate-to-spike encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rste_pkg;

   localparam int TIME_W    = 48;
   localparam int SAMPLE_W  = 16;
   localparam int CHAN_W    = 6;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;
   localparam int TSTEP_W   = 20;
   localparam int RATEQ_W   = 24;
   localparam int RATE_W    = 42;
   localparam int DVD_W     = 96;
   localparam int DSR_W     = 48;
   localparam int STEP_W    = 7;
   localparam int NUMER_W   = 44;

   // 1e6 * 2^24: microseconds per second in the Hz*2^24 rate scale
   localparam logic [NUMER_W-1:0] US_NUMER = 44'd16777216000000;

   localparam logic [STEP_W-1:0] DIV_STEPS_IV = 7'd44;
   localparam logic [STEP_W-1:0] DIV_STEPS_MD = 7'd96;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMESTEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LO_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HI_RATE  = 2'd2;

   localparam logic [TSTEP_W-1:0] TIMESTEP_RESET = 20'd10000;
   localparam logic [RATEQ_W-1:0] LO_RATE_RESET  = 24'd0;
   localparam logic [RATEQ_W-1:0] HI_RATE_RESET  = 24'd25600;

   typedef struct packed {
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] rate_sample;
      logic                       end_of_tick;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] spike_channel;
      logic [TIME_W-1:0] spike_time_us;
      logic              last_of_run;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] prev_sample;
      logic [TIME_W-1:0]          fired_us;
      logic [TIME_W-1:0]          due_us;
      logic                       next_valid;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_LOAD,
      OP_DIV_IV,
      OP_IV,
      OP_APPLY,
      OP_MUL,
      OP_DIV_R,
      OP_RESCALE,
      OP_EMIT,
      OP_WRITE
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_RATE,
      ST_WAIT_IV,
      ST_DECIDE,
      ST_MUL,
      ST_DIV_R,
      ST_WAIT_R,
      ST_EMIT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_of_range;
      logic rate_pos;
      logic div_done;
      logic need_rescale;
      logic mul_last;
      logic due;
      logic out_free;
   } ctrl_sts_type;

endpackage

`default_nettype wire

FILE: rtl/rste_ram.sv
// ----------------------------------------------------------------------------
// rste_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rste_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: rtl/rste_div.sv
// ----------------------------------------------------------------------------
// rste_div
// Restoring divider, one quotient bit per cycle, dividend MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module rste_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rste_pkg::DVD_W-1:0]  dividend,
   input  wire logic [rste_pkg::DSR_W-1:0]  divisor,
   input  wire logic [rste_pkg::STEP_W-1:0] steps,
   output logic                             done,
   output logic      [rste_pkg::DSR_W-1:0]  quotient
);
   import rste_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DSR_W-1:0]  dsr_ff;
   logic [DSR_W-1:0]  rem_ff;
   logic [DSR_W-1:0]  quo_ff;
   logic [DSR_W:0]    trial;
   logic              fits;
   logic [DSR_W:0]    rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DVD_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? (trial - {1'b0, dsr_ff}) : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // quotient keeps its low bits only; callers guarantee it fits
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= rem_in[DSR_W-1:0];
         quo_ff <= {quo_ff[DSR_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/rste_ctrl.sv
// ----------------------------------------------------------------------------
// rste_ctrl
// Sequencer: clearing pass, interval, rescale and spike emission per item.
// ----------------------------------------------------------------------------
`default_nettype none

module rste_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rste_pkg::ctrl_sts_type sts,
   output rste_pkg::ctrl_cmd_type      cmd
);
   import rste_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_READ;
         ST_READ:    state_in = sts.out_of_range ? ST_WRITE : ST_RATE;
         ST_RATE:    state_in = sts.rate_pos ? ST_WAIT_IV : ST_DECIDE;
         ST_WAIT_IV: if (sts.div_done) state_in = ST_DECIDE;
         ST_DECIDE:  state_in = sts.need_rescale ? ST_MUL : ST_EMIT;
         ST_MUL:     if (sts.mul_last) state_in = ST_DIV_R;
         ST_DIV_R:   state_in = ST_WAIT_R;
         ST_WAIT_R:  if (sts.div_done) state_in = ST_EMIT;
         ST_EMIT:    if (!sts.due) state_in = ST_WRITE;
         ST_WRITE:   state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_CLEAR:   cmd.op = OP_CLEAR;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_ACCEPT;
         end
         ST_READ:    cmd.op = OP_LOAD;
         ST_RATE:    cmd.op = OP_DIV_IV;
         ST_WAIT_IV: if (sts.div_done) cmd.op = OP_IV;
         ST_DECIDE:  cmd.op = OP_APPLY;
         ST_MUL:     cmd.op = OP_MUL;
         ST_DIV_R:   cmd.op = OP_DIV_R;
         ST_WAIT_R:  if (sts.div_done) cmd.op = OP_RESCALE;
         ST_EMIT:    if (sts.due && sts.out_free) cmd.op = OP_EMIT;
         ST_WRITE:   cmd.op = OP_WRITE;
         default:    cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/rste_dpath.sv
// ----------------------------------------------------------------------------
// rste_dpath
// Datapath: settings, time base, channel state memory, rate multiply,
// shared divider, rescale product and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rste_dpath #(
   parameter int CHANNELS   = 64,
   parameter int MAX_SPIKES = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rste_pkg::req_type              req_data,
   output rste_pkg::rsp_type                   rsp_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic                           csr_we,
   input  wire logic [rste_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rste_pkg::CSR_W-1:0]     csr_wdata,
   input  wire rste_pkg::ctrl_cmd_type         cmd,
   output rste_pkg::ctrl_sts_type              sts
);
   import rste_pkg::*;

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CAP    = (MAX_SPIKES < 16) ? MAX_SPIKES : 16;
   localparam int CNT_W  = $clog2(CAP + 1);

   logic [TSTEP_W-1:0]  timestep_ff;
   logic [RATEQ_W-1:0]  rmin_ff;
   logic [RATEQ_W-1:0]  rmax_ff;
   logic [TIME_W-1:0]   now_ff;

   logic [CHAN_W-1:0]          ch_ff;
   logic signed [SAMPLE_W-1:0] samp_ff;
   logic                       eot_ff;
   logic [TIME_W-1:0]          t_ff;
   logic [TIME_W-1:0]          endt_ff;

   entry_type          e_ff;
   logic signed [RATE_W-1:0] rate_ff;
   logic [TIME_W-1:0]  iv_ff;
   logic               v_ff;
   logic [TIME_W-1:0]  old_ff;
   logic [TIME_W-1:0]  rem_ff;
   logic [DVD_W-1:0]   prod_ff;
   logic [1:0]         mcnt_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [ADDR_W-1:0]  clr_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   entry_type          rd_entry;
   entry_type          wr_entry;
   entry_type          clr_entry;
   logic [$bits(entry_type)-1:0] rd_word;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;

   logic signed [RATEQ_W:0]  diff;
   logic signed [SAMPLE_W:0] ofs;
   logic signed [RATE_W-1:0] rate_in;
   logic               changed;
   logic [TIME_W-1:0]  rem_raw;
   logic [TIME_W-1:0]  rem_in;
   logic [15:0]        chunk;
   logic [63:0]        partial;
   logic [TIME_W-1:0]  next_in;
   logic               more;
   logic               last_in;
   logic               out_range;
   logic               div_start;
   logic [DVD_W-1:0]   div_dvd;
   logic [DSR_W-1:0]   div_dsr;
   logic [STEP_W-1:0]  div_steps;
   logic               div_done;
   logic [DSR_W-1:0]   div_q;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         timestep_ff <= TIMESTEP_RESET;
         rmin_ff     <= LO_RATE_RESET;
         rmax_ff     <= HI_RATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMESTEP: timestep_ff <= csr_wdata[TSTEP_W-1:0];
            CSR_LO_RATE:  rmin_ff     <= csr_wdata[RATEQ_W-1:0];
            CSR_HI_RATE:  rmax_ff     <= csr_wdata[RATEQ_W-1:0];
            default: ;
         endcase
      end
   end

   // state memory, swept once after reset
   assign clr_entry = '{prev_sample: {1'b1, {(SAMPLE_W-1){1'b0}}},
                        fired_us: '0, due_us: '0, next_valid: 1'b0};
   assign out_range = 32'(ch_ff) >= CHANNELS;
   assign ram_we    = (cmd.op == OP_CLEAR) || ((cmd.op == OP_WRITE) && !out_range);
   assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_ff : ADDR_W'(ch_ff);
   assign wr_entry  = (cmd.op == OP_CLEAR) ? clr_entry : e_ff;
   assign rd_entry  = entry_type'(rd_word);

   rste_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_entry),
      .raddr (ADDR_W'(req_data.channel)),
      .rdata (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         now_ff <= '0;
      end else begin
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + 1'b1;
         if ((cmd.op == OP_WRITE) && eot_ff) now_ff <= endt_ff;
      end
   end

   // R = min*2^16 + (s+32768)*(max-min), never negative
   always_comb begin
      diff    = $signed({1'b0, rmax_ff}) - $signed({1'b0, rmin_ff});
      ofs     = $signed({1'b0, ~samp_ff[SAMPLE_W-1], samp_ff[SAMPLE_W-2:0]});
      rate_in = $signed({2'b00, rmin_ff, 16'h0000}) + diff * ofs;
   end

   always_comb begin
      changed = samp_ff != e_ff.prev_sample;
      rem_raw = (e_ff.due_us > t_ff) ? (e_ff.due_us - t_ff) : '0;
      rem_in  = (rem_raw > (e_ff.due_us - e_ff.fired_us)) ?
                (e_ff.due_us - e_ff.fired_us) : rem_raw;
      chunk   = iv_ff[16*mcnt_ff +: 16];
      partial = chunk * rem_ff;
      next_in = e_ff.due_us + iv_ff;
      more    = next_in < endt_ff;
      last_in = (n_ff == CNT_W'(CAP - 1)) || !more;
   end

   // shared divider: interval, then rescaled remainder
   always_comb begin
      div_start = ((cmd.op == OP_DIV_IV) && sts.rate_pos) || (cmd.op == OP_DIV_R);
      if (cmd.op == OP_DIV_R) begin
         div_dvd   = prod_ff;
         div_dsr   = old_ff;
         div_steps = DIV_STEPS_MD;
      end else begin
         div_dvd   = {US_NUMER, {(DVD_W-NUMER_W){1'b0}}};
         div_dsr   = DSR_W'($unsigned(rate_ff));
         div_steps = DIV_STEPS_IV;
      end
   end

   rste_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            ch_ff   <= req_data.channel;
            samp_ff <= req_data.rate_sample;
            eot_ff  <= req_data.end_of_tick;
            t_ff    <= now_ff;
            endt_ff <= now_ff + TIME_W'(timestep_ff);
            n_ff    <= '0;
         end
         OP_LOAD: begin
            e_ff    <= rd_entry;
            rate_ff <= rate_in;
         end
         OP_DIV_IV: begin
            if (!sts.rate_pos) begin
               iv_ff <= '0;
               v_ff  <= 1'b0;
            end
         end
         OP_IV: begin
            iv_ff <= div_q;
            v_ff  <= 1'b1;
         end
         OP_APPLY: begin
            prod_ff <= '0;
            mcnt_ff <= '0;
            old_ff  <= e_ff.due_us - e_ff.fired_us;
            rem_ff  <= rem_in;
            if (changed) begin
               e_ff.prev_sample <= samp_ff;
               if (!v_ff) begin
                  e_ff.next_valid <= 1'b0;
               end else if (!e_ff.next_valid || (e_ff.due_us == e_ff.fired_us)) begin
                  e_ff.due_us     <= t_ff + iv_ff;
                  e_ff.next_valid <= 1'b1;
               end
            end
         end
         OP_MUL: begin
            prod_ff <= prod_ff + (DVD_W'(partial) << {mcnt_ff, 4'b0000});
            mcnt_ff <= mcnt_ff + 1'b1;
         end
         OP_RESCALE: e_ff.due_us <= t_ff + div_q;
         OP_EMIT: begin
            rsp_ff.spike_channel <= ch_ff;
            rsp_ff.spike_time_us <= e_ff.due_us;
            rsp_ff.last_of_run   <= last_in;
            rsp_ff.overflow      <= last_in && more;
            e_ff.fired_us        <= e_ff.due_us;
            e_ff.due_us          <= next_in;
            n_ff                 <= n_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sts.clr_last     = clr_ff == ADDR_W'(CHANNELS - 1);
      sts.out_of_range = out_range;
      sts.rate_pos     = !rate_ff[RATE_W-1] && (rate_ff != '0);
      sts.div_done     = div_done;
      sts.need_rescale = changed && v_ff && e_ff.next_valid &&
                         (e_ff.due_us != e_ff.fired_us);
      sts.mul_last     = mcnt_ff == 2'd2;
      sts.due          = e_ff.next_valid && (e_ff.due_us < endt_ff) &&
                         (n_ff < CNT_W'(CAP));
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

FILE: rtl/rate_to_spike_encoder.sv
// ----------------------------------------------------------------------------
// rate_to_spike_encoder
// Regular rate coding: per-channel rate samples in, periodic spike times out.
// ----------------------------------------------------------------------------
//  port group  | direction | handshake            | payload
//  req_        | in        | req_valid/req_ready  | channel, rate_sample, end_of_tick
//  rsp_        | out       | rsp_valid/rsp_ready  | spike_channel, spike_time_us, flags
//  csr_        | in        | csr_we               | csr_index, csr_wdata
//
// One transaction at a time. The divider gives one quotient bit per cycle,
// 44 bits for the interval; when a changed sample rescales the pending
// interval, a product and a 96-bit divide follow. Spikes then go out one
// per cycle while rsp_ready is high.
// After reset a clearing pass writes every state entry before req_ready rises.
// A stalled result holds the sequencer only while a further spike is due.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_to_spike_encoder #(
   parameter int CHANNELS   = 64,
   parameter int MAX_SPIKES = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire rste_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output rste_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [rste_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rste_pkg::CSR_W-1:0]     csr_wdata
);
   import rste_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   rste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rste_dpath #(
      .CHANNELS   (CHANNELS),
      .MAX_SPIKES (MAX_SPIKES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef ASSERT_OFF
   // more spikes of the current transaction still to come: no new item taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> !req_ready)
      else $error("item accepted mid-run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.last_of_run)
      else $error("overflow on a result that is not the last");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held across an accepted item");
`endif

endmodule

`default_nettype wire

FILE: tb/rate_to_spike_encoder_test.sv
// ----------------------------------------------------------------------------
// rate_to_spike_encoder_test
// Self-checking bench for the rate-to-spike encoder. A spike-time model in a
// small class follows every accepted sample and queues the spikes it should
// cause. Each spike that comes out is checked against the oldest one queued.
// The run steps through several register settings, extremes included.
// Both handshakes see random gaps, plus one long result hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_to_spike_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rste_pkg::*;

   class spike_predictor;
      logic [TSTEP_W-1:0]         timestep;
      logic [RATEQ_W-1:0]         lo_rate;
      logic [RATEQ_W-1:0]         hi_rate;
      logic [TIME_W-1:0]          now_us;
      logic signed [SAMPLE_W-1:0] held_sample [64];
      logic [TIME_W-1:0]          last_us [64];
      logic [TIME_W-1:0]          next_us [64];
      logic                       next_ok [64];
      rsp_type                    pending_spikes [$];
      int                         errors;

      // interval in us for a sample; 0 means the channel never spikes
      function longint unsigned interval_us(logic signed [SAMPLE_W-1:0] s);
         longint r;
         r = longint'(lo_rate) * 65536
             + (longint'(s) + 32768) * (longint'(hi_rate) - longint'(lo_rate));
         if (r <= 0)
            return 0;
         return longint'(64'd16777216000000) / r;
      endfunction

      function void reset_state();
         longint unsigned iv;
         timestep = TIMESTEP_RESET;
         lo_rate  = LO_RATE_RESET;
         hi_rate  = HI_RATE_RESET;
         now_us   = '0;
         errors   = 0;
         iv = interval_us(-16'sd32768);
         for (int c = 0; c < 64; c++) begin
            held_sample[c] = -16'sd32768;
            last_us[c]     = '0;
            next_us[c]     = (iv != 0) ? iv[TIME_W-1:0] : '0;
            next_ok[c]     = (iv != 0);
         end
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_TIMESTEP: timestep = val[TSTEP_W-1:0];
            CSR_LO_RATE:  lo_rate  = val;
            CSR_HI_RATE:  hi_rate  = val;
            default: ;
         endcase
      endfunction

      function void note_sample(req_type r);
         logic [5:0]        ch;
         logic [TIME_W-1:0] t, end_t, old_iv, rem;
         longint unsigned   iv;
         logic [127:0]      quot;
         int                n;
         rsp_type           o;
         ch    = r.channel;
         t     = now_us;
         end_t = t + TIME_W'(timestep);
         iv    = interval_us(r.rate_sample);
         n     = 0;
         if (r.rate_sample != held_sample[ch]) begin
            if (iv == 0) begin
               next_ok[ch] = 1'b0;
            end else if (!next_ok[ch] || next_us[ch] == last_us[ch]) begin
               next_us[ch] = t + iv[TIME_W-1:0];
               next_ok[ch] = 1'b1;
            end else begin
               old_iv = next_us[ch] - last_us[ch];
               rem = (next_us[ch] > t) ? next_us[ch] - t : '0;
               if (rem > old_iv)
                  rem = old_iv;
               quot = (128'(iv) * 128'(rem)) / 128'(old_iv);
               next_us[ch] = t + quot[TIME_W-1:0];
            end
            held_sample[ch] = r.rate_sample;
         end
         while (next_ok[ch] && next_us[ch] < end_t && n < 16) begin
            o.spike_channel = ch;
            o.spike_time_us = next_us[ch];
            o.last_of_run   = 1'b0;
            o.overflow      = 1'b0;
            pending_spikes.push_back(o);
            last_us[ch] = next_us[ch];
            next_us[ch] = next_us[ch] + iv[TIME_W-1:0];
            n++;
         end
         if (n > 0) begin
            pending_spikes[pending_spikes.size()-1].last_of_run = 1'b1;
            if (next_ok[ch] && next_us[ch] < end_t)
               pending_spikes[pending_spikes.size()-1].overflow = 1'b1;
         end
         if (r.end_of_tick)
            now_us = end_t;
      endfunction

      function void check_spike(rsp_type got);
         rsp_type want;
         if (pending_spikes.size() == 0) begin
            $error("unexpected spike: channel %0d time %0d", got.spike_channel,
                   got.spike_time_us);
            errors++;
            return;
         end
         want = pending_spikes.pop_front();
         if (got.spike_channel !== want.spike_channel) begin
            $error("spike_channel: expected %0d, got %0d", want.spike_channel,
                   got.spike_channel);
            errors++;
         end
         if (got.spike_time_us !== want.spike_time_us) begin
            $error("spike_time_us: expected %0d, got %0d", want.spike_time_us,
                   got.spike_time_us);
            errors++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   got.last_of_run);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            errors++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 400;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TIMESTEP;
   logic [CSR_W-1:0]     csr_wdata = '0;

   spike_predictor       model = new();
   int                   cycles = 0;
   bit                   hold_request = 0;
   bit                   calm = 0;
   logic signed [15:0]   chan_sample [64];

   rate_to_spike_encoder DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         model.check_spike(rsp_data);
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 70)
         return 0;
      if (p < 95)
         return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, and one long hold-off when asked
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (SETTLE) @(posedge clock);
            hold_request = 0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
               stall_left = pick_gap() + 1;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      model.set_reg(idx, val);
      csr_we    <= 1'b0;
   endtask

   task automatic send_sample(logic [5:0] ch, logic signed [15:0] s, logic eot);
      req_type r;
      int gap;
      r.channel = ch;
      r.rate_sample = s;
      r.end_of_tick = eot;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      model.note_sample(r);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (model.pending_spikes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // mostly a few busy channels holding their sample, the rest noise
   task automatic send_random();
      logic [5:0] ch;
      int p;
      ch = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 3)) : 6'($urandom);
      p = $urandom_range(0, 99);
      if (p < 12)
         chan_sample[ch] = 16'($urandom);
      else if (p < 16)
         chan_sample[ch] = ($urandom_range(0, 1) != 0) ? 16'sh7fff : -16'sh8000;
      send_sample(ch, chan_sample[ch], $urandom_range(0, 3) == 0);
   endtask

   task automatic run_phase(logic [19:0] ts, logic [23:0] rmin, logic [23:0] rmax);
      write_reg(CSR_TIMESTEP, 24'(ts));
      write_reg(CSR_LO_RATE, rmin);
      write_reg(CSR_HI_RATE, rmax);
      calm = ($urandom_range(0, 3) == 0);
      repeat (17) send_random();
      wait_drained();
   endtask

   initial begin
      model.reset_state();
      for (int c = 0; c < 64; c++)
         chan_sample[c] = -16'sh8000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, 100 Hz at full scale, 10 ms ticks
      send_sample(6'd0, 16'sh7fff, 1'b0);
      send_sample(6'd63, -16'sh8000, 1'b0);  // unchanged, rate zero
      send_sample(6'd63, 16'sh0000, 1'b1);
      send_sample(6'd1, 16'sh7fff, 1'b1);
      repeat (3) send_sample(6'd0, 16'sh7fff, 1'b1);
      send_sample(6'd0, 16'sh0000, 1'b0);    // rescale of a running interval
      send_sample(6'd0, 16'sh0000, 1'b1);
      send_sample(6'd0, -16'sh8000, 1'b1);   // to rate zero
      send_sample(6'd0, 16'sh7fff, 1'b0);    // from rate zero
      send_sample(6'd0, 16'sh7fff, 1'b1);
      repeat (4) send_sample(6'd2, 16'sh5555, 1'b1);
      send_sample(6'd1, 16'sh2aaa, 1'b0);    // channel 1 long overdue
      send_sample(6'd63, -16'sh0001, 1'b1);
      send_sample(6'd63, 16'sh4000, 1'b1);
      send_sample(6'd63, 16'sh4000, 1'b1);
      wait_drained();

      run_phase(20'd1000, 24'd0, 24'd256000);
      // pause mid-stream until every spike is out, then carry on
      repeat (10) send_random();
      wait_drained();
      run_phase(20'hfffff, 24'hffffff, 24'hffffff);
      // extremes: runs overflow the spike cap, receiver holds off while sender pushes
      hold_request = 1;
      repeat (25) send_random();
      wait_drained();
      run_phase(20'd1, 24'd0, 24'd0);
      run_phase(20'd5000, 24'd256000, 24'd2560);
      run_phase(20'd0, 24'd25600, 24'd51200);
      run_phase(20'($urandom_range(100, 20000)), 24'($urandom_range(0, 512000)),
                24'($urandom_range(0, 512000)));
      run_phase(20'd10000, 24'd0, 24'd25600);

      if (model.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

`default_nettype wire
